@@ design/bfsa_pkg.sv @@
// shared types and constants for the best-fit segment allocator
package bfsa_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_ALLOC  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] stop;
    logic [15:0] size;
    logic [7:0]  owner;
  } seg_t;

  // what a cell hands to its right neighbour during a search pass
  typedef struct packed {
    logic        found;
    logic [15:0] best_size;
  } srch_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic        search;   // evaluate fit and pass best along the chain
    logic        insert;   // apply split at the chosen entry
    logic        append;   // write the appended segment at the count
    logic [15:0] req;
    logic [7:0]  pid;
    logic [15:0] sa;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_RESP
  } state_t;

endpackage

@@ design/bfsa_cell.sv @@
// one table entry of the allocator chain with its fit compare
module bfsa_cell
  import bfsa_pkg::*;
#(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] my_idx,
  input  logic [IDX_W:0]   count,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W:0]   best_idx,   // chosen entry, valid during insert
  input  logic             split,
  input  seg_t             left_seg,   // neighbour below, for the shift
  input  srch_t            srch_in,
  output srch_t            srch_out,
  output logic             take,       // this cell becomes the best so far
  output seg_t             seg
);

  logic  live;
  logic  fits;
  logic [IDX_W:0] me;
  seg_t  seg_next;

  assign me   = {1'b0, my_idx};
  assign live = me < count;
  assign fits = live && (seg.owner == 8'd0) && (seg.size >= ctl.req);
  assign take = ctl.search && fits &&
                (!srch_in.found || (seg.size < srch_in.best_size));

  always_comb begin
    srch_out = srch_in;
    if (take) begin
      srch_out.found     = 1'b1;
      srch_out.best_size = seg.size;
    end
  end

  always_comb begin
    seg_next = seg;
    if (ctl.append && (me == count)) begin
      seg_next.start = ctl.sa;
      seg_next.size  = ctl.req;
      seg_next.stop  = ctl.sa + ctl.req - 16'd1;
      seg_next.owner = ctl.pid;
    end else if (ctl.insert) begin
      if (me == best_idx) begin
        seg_next.owner = ctl.pid;
        if (split) begin
          seg_next.size = ctl.req;
          seg_next.stop = seg.start + ctl.req - 16'd1;
        end
      end else if (split && (me == best_idx + 1'b1)) begin
        seg_next.owner = 8'd0;
        seg_next.start = left_seg.start + ctl.req;
        seg_next.stop  = left_seg.stop;
        seg_next.size  = left_seg.size - ctl.req;
      end else if (split && (me > best_idx + 1'b1) && (me <= count)) begin
        seg_next = left_seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
  end

endmodule

@@ design/best_fit_segment_allocator.sv @@
// Best-fit segment allocator: a row of TABLE_DEPTH cells each holding one segment. A clear or
// append goes from idle through the apply state to the response state. An allocate adds the
// search pass: the compare chain is broken into groups of 8 cells with a register between
// groups, and the search state takes the groups in turn; the split and shift of later entries
// then happens in the apply state across all cells. One transaction is in flight at a time;
// the result sits in an output register and is held while out_ready stays low, and ready
// returns once the result is taken.
module best_fit_segment_allocator
  import bfsa_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] req_len,
  input  logic [7:0]  owner_id,
  input  logic [15:0] base_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] block_start,
  output logic [15:0] block_end,
  output logic [15:0] block_size,
  output logic [7:0]  block_owner,
  output logic [5:0]  entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int GRP   = 8;
  localparam int NGRP  = (TABLE_DEPTH + GRP - 1) / GRP;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP + 1) : 1;

  state_t         state, state_next;
  logic [IDX_W:0] count;
  logic [IDX_W:0] count_next;
  logic [1:0]     f_reg;
  cell_ctl_t      ctl;
  logic [GW-1:0]  grp;
  srch_t          carry;         // best so far, registered between groups
  srch_t          carry_next;
  logic [IDX_W:0] best_idx;
  logic [IDX_W:0] grp_best;
  logic           grp_take;
  logic           split;
  logic           blocked;       // split needed but the table is full
  seg_t           chosen;
  logic [1:0]     r_status;
  seg_t           r_blk;

  seg_t  segs    [TABLE_DEPTH];
  srch_t chain   [TABLE_DEPTH];
  logic  takes   [TABLE_DEPTH];
  cell_ctl_t cctl [TABLE_DEPTH];

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      seg_t lft;
      srch_t sin;
      cell_ctl_t c;
      if (g == 0) begin : g_l0
        assign lft = '0;
      end else begin : g_ln
        assign lft = segs[g-1];
      end
      // a group starts from the registered carry
      if (g % GRP == 0) begin : g_s0
        assign sin = carry;
      end else begin : g_sn
        assign sin = chain[g-1];
      end
      // only the group under evaluation searches this cycle
      always_comb begin
        c = ctl;
        c.search = ctl.search && (grp == GW'(g / GRP));
        c.insert = ctl.insert && !blocked;
      end
      assign cctl[g] = c;
      bfsa_cell #(.IDX_W(IDX_W)) u_cell (
        .clk      (clk),
        .my_idx   (IDX_W'(g)),
        .count    (count),
        .ctl      (cctl[g]),
        .best_idx (best_idx),
        .split    (split),
        .left_seg (lft),
        .srch_in  (sin),
        .srch_out (chain[g]),
        .take     (takes[g]),
        .seg      (segs[g])
      );
    end
  endgenerate

  // last cell of the active group gives the carry; latest taker gives the index
  always_comb begin
    carry_next = carry;
    grp_take   = 1'b0;
    grp_best   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k / GRP == int'(grp)) begin
        carry_next = chain[k];
        if (takes[k]) begin
          grp_take = 1'b1;
          grp_best = (IDX_W+1)'(k);
        end
      end
    end
  end

  assign chosen  = segs[best_idx[IDX_W-1:0]];
  assign split   = carry.found && (chosen.size > ctl.req) &&
                   (count < (IDX_W+1)'(TABLE_DEPTH));
  assign blocked = (chosen.size > ctl.req) && !split;

  always_comb begin
    r_status   = ST_OK;
    r_blk      = '0;
    count_next = count;
    case (f_reg)
      FUNC_CLEAR: count_next = '0;
      FUNC_APPEND: begin
        if (count >= (IDX_W+1)'(TABLE_DEPTH)) begin
          r_status = ST_FULL;
        end else begin
          count_next  = count + 1'b1;
          r_blk.start = ctl.sa;
          r_blk.stop  = ctl.sa + ctl.req - 16'd1;
          r_blk.size  = ctl.req;
          r_blk.owner = ctl.pid;
        end
      end
      FUNC_ALLOC: begin
        if (!carry.found) begin
          r_status = ST_NOFIT;
        end else if (blocked) begin
          r_status = ST_FULL;
        end else begin
          r_blk.start = chosen.start;
          r_blk.owner = ctl.pid;
          if (split) begin
            count_next = count + 1'b1;
            r_blk.size = ctl.req;
            r_blk.stop = chosen.start + ctl.req - 16'd1;
          end else begin
            r_blk.size = chosen.size;
            r_blk.stop = chosen.stop;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = (func == FUNC_ALLOC) ? S_SEARCH : S_APPLY;
      S_SEARCH: if (grp == GW'(NGRP - 1)) state_next = S_APPLY;
      S_APPLY:  state_next = S_RESP;
      S_RESP:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ctl   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            f_reg      <= func;
            ctl.req    <= req_len;
            ctl.pid    <= owner_id;
            ctl.sa     <= base_addr;
            ctl.search <= (func == FUNC_ALLOC);
            ctl.append <= (func == FUNC_APPEND);
            ctl.insert <= 1'b0;
            grp        <= '0;
            carry      <= '0;
            best_idx   <= '0;
          end
        end
        S_SEARCH: begin
          carry <= carry_next;
          if (grp_take) best_idx <= grp_best;
          grp <= grp + 1'b1;
          // cell writes fire in the apply cycle
          if (grp == GW'(NGRP - 1)) begin
            ctl.search <= 1'b0;
            ctl.insert <= carry_next.found;
          end
        end
        S_APPLY: begin
          status      <= r_status;
          block_start <= r_blk.start;
          block_end   <= r_blk.stop;
          block_size  <= r_blk.size;
          block_owner <= r_blk.owner;
          count       <= count_next;
          ctl.insert  <= 1'b0;
          ctl.append  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign entry_count = 6'(count);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (IDX_W+1)'(TABLE_DEPTH)) else $error("count past depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_APPLY) |=> (count == $past(count))) else $error("count moved outside apply");
  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOFIT) |-> (block_size == 16'd0 && block_owner == 8'd0))
    else $error("no-fit result carries a block");

endmodule
